/* hdl/gipps_car_following_accel_assert.svh */
// Assertion macros used by the top-level RTL file
`ifndef GIPPS_CAR_FOLLOWING_ACCEL_ASSERT_SVH
`define GIPPS_CAR_FOLLOWING_ACCEL_ASSERT_SVH

// implication under reset
`define GCF_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication under reset
`define GCF_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

/* hdl/gcf_pkg.sv */
`default_nettype none
package gcf_pkg;
    localparam int IdxW = 3;
    localparam logic [IdxW-1:0] REG_DESIRED_SPEED = 3'd0;
    localparam logic [IdxW-1:0] REG_SPEED_FACTOR  = 3'd1;
    localparam logic [IdxW-1:0] REG_SPEED_LIMIT   = 3'd2;
    localparam logic [IdxW-1:0] REG_MAX_ACCEL     = 3'd3;
    localparam logic [IdxW-1:0] REG_COMFORT_DECEL = 3'd4;
    localparam logic [IdxW-1:0] REG_MIN_GAP       = 3'd5;
    localparam logic [IdxW-1:0] REG_STEP_TIME     = 3'd6;

    localparam logic [1:0] BOUND_SAFE    = 2'd0;
    localparam logic [1:0] BOUND_ACCEL   = 2'd1;
    localparam logic [1:0] BOUND_DESIRED = 2'd2;

    // radicand < 2^57, root < 2^29
    localparam int RadW  = 58;
    localparam int RootW = 29;
    // quotient numerator (diff<2^30)<<6
    localparam int NumW  = 36;
    localparam int QW    = 36;

    typedef struct packed {
        logic [15:0] desired_speed;
        logic [9:0]  speed_factor;
        logic [15:0] speed_limit;
        logic [11:0] max_accel;
        logic [11:0] comfort_decel;
        logic [15:0] min_gap;
        logic [15:0] step_time;
    } cfg_t;
endpackage
`default_nettype wire

/* hdl/gipps_car_following_accel.sv */
`default_nettype none
// Pipeline order: arithmetic stages, square root, final choice, divider and output register.
// Throughput: one word per cycle; the whole pipe stalls only when the output
// register is full and m_axis_tready is low.
// Reset: aresetn, synchronous, active low, clears valid bits and restores
// the register defaults; no clearing pass.
module gipps_car_following_accel (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // own_front_pos[31:0], own_speed[47:32], obstacle_pos[79:48],
    // obstacle_speed[95:80]
    input  wire logic [95:0] s_axis_tdata,
    // has_obstacle
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // new_accel[15:0]
    output logic [15:0]      m_axis_tdata,
    // limiting_bound[1:0]
    output logic [1:0]       m_axis_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import gcf_pkg::*;
    `include "gipps_car_following_accel_assert.svh"

    localparam int Depth = 3 + RootW + 1 + NumW;
    cfg_t cfg;
    logic en;
    logic [Depth-1:0] vld_reg;
    logic m_valid_reg;

    gcf_cfg u_cfg (.aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_index,
                   .cfg_data, .cfg);

    assign en = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: products and differences
    logic [15:0] t1;
    logic [27:0] bt1_reg, at1_reg;
    logic [25:0] dprod1_reg;
    logic [15:0] lim1_reg, spd1_reg;
    logic [31:0] vl2_1_reg;
    logic [33:0] gap1_reg;
    logic        obst1_reg;
    logic [11:0] b1_reg;
    logic [15:0] t1_reg;
    assign t1 = (cfg.step_time == 16'd0) ? 16'd1 : cfg.step_time;

    always_ff @(posedge aclk) begin
        if (en) begin
            bt1_reg    <= 28'(cfg.comfort_decel) * 28'(t1);
            at1_reg    <= 28'(cfg.max_accel) * 28'(t1);
            dprod1_reg <= 26'(cfg.desired_speed) * 26'(cfg.speed_factor);
            lim1_reg   <= cfg.speed_limit;
            spd1_reg   <= s_axis_tdata[47:32];
            vl2_1_reg  <= 32'(s_axis_tdata[95:80]) * 32'(s_axis_tdata[95:80]);
            gap1_reg   <= {2'b00, s_axis_tdata[79:48]} - {2'b00, s_axis_tdata[31:0]}
                        - 34'(cfg.min_gap);
            obst1_reg  <= s_axis_tuser;
            b1_reg     <= cfg.comfort_decel;
            t1_reg     <= t1;
        end
    end

    // stage 2: squares, distance product, bounds
    logic [55:0] bt2sq_reg;
    logic [45:0] bg2_reg;
    logic [31:0] vl2_2_reg;
    logic [21:0] bt6_2_reg;
    logic [22:0] vacc2_reg;
    logic [19:0] vdes2_reg;
    logic [19:0] own2_reg;
    logic        obst2_reg;
    logic [15:0] t2_reg;
    logic [17:0] vd_raw;
    logic [32:0] g1;
    assign vd_raw = dprod1_reg[25:8];
    assign g1 = gap1_reg[33] ? 33'd0 : gap1_reg[32:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            bt2sq_reg <= 56'(bt1_reg) * 56'(bt1_reg);
            bg2_reg   <= 46'(b1_reg) * 46'(g1);
            vl2_2_reg <= vl2_1_reg;
            bt6_2_reg <= bt1_reg[27:6];
            vacc2_reg <= 23'({spd1_reg, 4'b0}) + 23'(at1_reg[27:6]);
            vdes2_reg <= (vd_raw > 18'(lim1_reg)) ? {lim1_reg, 4'b0} : {vd_raw[15:0], 4'b0};
            own2_reg  <= {spd1_reg, 4'b0};
            obst2_reg <= obst1_reg;
            t2_reg    <= t1_reg;
        end
    end

    // stage 3: radicand and free-flow choice
    logic [RadW-1:0] rad3_reg;
    logic [21:0] bt6_3_reg;
    logic [19:0] vnf3_reg;
    logic [1:0]  code3_reg;
    logic [19:0] own3_reg;
    logic        obst3_reg;
    logic [15:0] t3_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            rad3_reg  <= RadW'(bt2sq_reg[55:12]) + (RadW'(vl2_2_reg) << 8)
                       + (RadW'(bg2_reg) << 9);
            bt6_3_reg <= bt6_2_reg;
            // free-flow bound stays below the desired bound, so 20 bits hold it
            if (vacc2_reg < 23'(vdes2_reg)) begin
                vnf3_reg  <= 20'(vacc2_reg);
                code3_reg <= BOUND_ACCEL;
            end else begin
                vnf3_reg  <= vdes2_reg;
                code3_reg <= BOUND_DESIRED;
            end
            own3_reg  <= own2_reg;
            obst3_reg <= obst2_reg;
            t3_reg    <= t2_reg;
        end
    end

    logic [RootW-1:0] root;
    logic [63:0] side_o;
    gcf_isqrt u_sqrt (.aclk, .en, .rad(rad3_reg),
        .side_in({bt6_3_reg, vnf3_reg, code3_reg, own3_reg[18:0], obst3_reg}),
        .root, .side_out(side_o));
    // own speed top bit: reconstruct via separate delay of t and own msb
    logic [15:0] t_d [RootW+1];
    logic        om_d [RootW+1];
    assign t_d[0]  = t3_reg;
    assign om_d[0] = own3_reg[19];
    for (genvar k = 0; k < RootW; k++) begin : g_dly
        logic [15:0] tq;
        logic        oq;
        always_ff @(posedge aclk) begin
            if (en) begin
                tq <= t_d[k];
                oq <= om_d[k];
            end
        end
        assign t_d[k+1]  = tq;
        assign om_d[k+1] = oq;
    end

    // stage after root: final choice and difference
    logic [21:0] bt6_s;
    logic [19:0] vnf_s;
    logic [1:0]  code_s;
    logic [18:0] own_lo;
    logic [19:0] own_s;
    logic        obst_s;
    logic [29:0] vsafe;
    logic [29:0] vnew;
    logic [1:0]  code_n;
    assign {bt6_s, vnf_s, code_s, own_lo, obst_s} = side_o;
    assign own_s = {om_d[RootW], own_lo};
    // wraps like the unsigned model when root < bT (huge value, never wins)
    assign vsafe = 30'(root) - 30'(bt6_s);

    always_comb begin
        vnew = 30'(vnf_s);
        code_n = code_s;
        if (obst_s && (vsafe < 30'(vnf_s)) && (root >= 29'(bt6_s))) begin
            vnew = vsafe;
            code_n = BOUND_SAFE;
        end
    end

    logic [NumW-1:0] num_reg;
    logic [15:0] den_reg;
    logic [2:0]  side_d_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            if (vnew >= 30'(own_s)) begin
                num_reg <= NumW'(vnew - 30'(own_s)) << 6;
                side_d_reg <= {1'b0, code_n};
            end else begin
                num_reg <= NumW'(30'(own_s) - vnew) << 6;
                side_d_reg <= {1'b1, code_n};
            end
            den_reg <= t_d[RootW];
        end
    end

    logic [QW-1:0] quo;
    logic [2:0] side_q;
    gcf_div u_div (.aclk, .en, .num(num_reg), .den(den_reg), .side_in(side_d_reg),
                   .quo, .side_out(side_q));

    logic [15:0] acc;
    always_comb begin
        if (!side_q[2]) acc = (quo > QW'(32767)) ? 16'sh7FFF : quo[15:0];
        else acc = (quo > QW'(32768)) ? 16'h8000 : 16'(-quo[15:0]);
    end

    logic [15:0] acc_reg;
    logic [1:0]  code_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[Depth-2:0], s_axis_tvalid};
            m_valid_reg <= vld_reg[Depth-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg  <= acc;
            code_reg <= side_q[1:0];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = acc_reg;
    assign m_axis_tuser  = code_reg;

    `GCF_ASSERT_IMP(a_no_input_stall, aclk, aresetn, !m_valid_reg, s_axis_tready)
    `GCF_ASSERT_NEXT(a_hold_out, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `GCF_ASSERT_IMP(a_code_range, aclk, aresetn, m_axis_tvalid,
        m_axis_tuser <= BOUND_DESIRED)
endmodule
`default_nettype wire

/* hdl/gcf_cfg.sv */
`default_nettype none
module gcf_cfg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    output gcf_pkg::cfg_t          cfg
);
    import gcf_pkg::*;
    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_DESIRED_SPEED: cfg_next.desired_speed = cfg_data[15:0];
                REG_SPEED_FACTOR:  cfg_next.speed_factor  = cfg_data[9:0];
                REG_SPEED_LIMIT:   cfg_next.speed_limit   = cfg_data[15:0];
                REG_MAX_ACCEL:     cfg_next.max_accel     = cfg_data[11:0];
                REG_COMFORT_DECEL: cfg_next.comfort_decel = cfg_data[11:0];
                REG_MIN_GAP:       cfg_next.min_gap       = cfg_data[15:0];
                REG_STEP_TIME:     cfg_next.step_time     = cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{desired_speed: 16'd7680, speed_factor: 10'd256,
                         speed_limit: 16'hFFFF, max_accel: 12'd384,
                         comfort_decel: 12'd768, min_gap: 16'd512,
                         step_time: 16'd1024};
        end else begin
            cfg_reg <= cfg_next;
        end
    end
endmodule
`default_nettype wire

/* hdl/gcf_isqrt.sv */
`default_nettype none
// Pipelined integer square root, one result bit per stage.
// Side data rides along; the whole pipe advances on en.
module gcf_isqrt (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic [gcf_pkg::RadW-1:0]     rad,
    input  wire logic [63:0]                  side_in,
    output logic      [gcf_pkg::RootW-1:0]    root,
    output logic      [63:0]                  side_out
);
    import gcf_pkg::*;
    localparam int N = RootW;
    logic [RadW-1:0]  rem_reg  [N+1];
    logic [RootW-1:0] r_reg    [N+1];
    logic [63:0]      side_reg [N+1];

    assign rem_reg[0]  = rad;
    assign r_reg[0]    = '0;
    assign side_reg[0] = side_in;

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam int B = N - 1 - k;
        logic [RadW+1:0] trial;
        logic [RadW-1:0] rem_q;
        logic [RootW-1:0] r_q;
        logic [63:0] s_q;
        // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
        assign trial = {2'b00, rem_reg[k]}
                     - (({{(RadW+2-RootW){1'b0}}, r_reg[k]} << (B + 1))
                        | ({{(RadW+1){1'b0}}, 1'b1} << (2 * B)));
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!trial[RadW+1]) begin
                    rem_q <= trial[RadW-1:0];
                    r_q   <= r_reg[k] | (RootW'(1) << B);
                end else begin
                    rem_q <= rem_reg[k];
                    r_q   <= r_reg[k];
                end
                s_q <= side_reg[k];
            end
        end
        assign rem_reg[k+1]  = rem_q;
        assign r_reg[k+1]    = r_q;
        assign side_reg[k+1] = s_q;
    end

    assign root     = r_reg[N];
    assign side_out = side_reg[N];
endmodule
`default_nettype wire

/* hdl/gcf_div.sv */
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
module gcf_div (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic [gcf_pkg::NumW-1:0]  num,
    input  wire logic [15:0]               den,
    input  wire logic [2:0]                side_in,
    output logic      [gcf_pkg::QW-1:0]    quo,
    output logic      [2:0]                side_out
);
    import gcf_pkg::*;
    localparam int N = NumW;
    logic [16:0]     rem_w [N+1];
    logic [NumW-1:0] n_w   [N+1];
    logic [QW-1:0]   q_w   [N+1];
    logic [15:0]     d_w   [N+1];
    logic [2:0]      s_w   [N+1];

    assign rem_w[0] = '0;
    assign n_w[0]   = num;
    assign q_w[0]   = '0;
    assign d_w[0]   = den;
    assign s_w[0]   = side_in;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [16:0] sh;
        logic [17:0] diff;
        logic [16:0] rem_q;
        logic [NumW-1:0] n_q;
        logic [QW-1:0] q_q;
        logic [15:0] d_q;
        logic [2:0] s_q;
        assign sh   = {rem_w[k][15:0], n_w[k][NumW-1]};
        assign diff = {1'b0, sh} - {2'b00, d_w[k]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_q <= diff[17] ? sh : diff[16:0];
                q_q   <= {q_w[k][QW-2:0], ~diff[17]};
                n_q   <= {n_w[k][NumW-2:0], 1'b0};
                d_q   <= d_w[k];
                s_q   <= s_w[k];
            end
        end
        assign rem_w[k+1] = rem_q;
        assign n_w[k+1]   = n_q;
        assign q_w[k+1]   = q_q;
        assign d_w[k+1]   = d_q;
        assign s_w[k+1]   = s_q;
    end

    assign quo      = q_w[N];
    assign side_out = s_w[N];
endmodule
`default_nettype wire
